// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain implication check under the reset qualifier.
`define DFV_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dfv assertion failed");

// Value must stay put in the cycle after the condition holds.
`define DFV_ASSERT_HOLD(label, clk, rst_n, cond, sig) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("dfv held value changed");

`endif

// ===== sv/dfv_pkg.sv =====
// Shared types, constants and helpers of the datagram frame validator.
// No dependencies.
`default_nettype none

package dfv_pkg;

  localparam int unsigned MAX_PAYLOAD   = 256;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned HDR_BYTES     = 4;
  localparam int unsigned CHK_LAST_OFS  = 5;
  localparam int unsigned FRAME_OVERHEAD = 6;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd1;

  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_BAD_MAGIC = 3'd2,
    VERDICT_BAD_LEN   = 3'd3,
    VERDICT_MISMATCH  = 3'd4
  } verdict_e;

  typedef enum logic [1:0] {
    OP_PAYLOAD = 2'd0,
    OP_VERDICT = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  // One queued transaction from the front to the back.
  typedef struct packed {
    op_e         kind;
    logic [7:0]  data;
    logic        payload;   // byte enters the running sums
    logic        pass;      // payload byte goes out
    verdict_e    pre;       // header verdict, OK means checksum still pending
    logic [15:0] check;
    logic [8:0]  flen;
  } op_t;

  function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 9'd255) ? 8'(s - 9'd255) : s[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/dfv_intf.sv =====
// Channel interfaces: byte input, result output and configuration write.
// Depends on dfv_pkg.
`default_nettype none

interface dfv_in_if import dfv_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface dfv_out_if import dfv_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [7:0] payload_out;
  logic [2:0] verdict;
  logic [8:0] frame_length;

  modport source (output valid, item_kind, payload_out, verdict, frame_length, input ready);
  modport sink   (input valid, item_kind, payload_out, verdict, frame_length, output ready);
endinterface

interface dfv_cfg_if import dfv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/dfv_front.sv =====
// Front end: configuration registers, byte position, header and checksum capture.
// Classifies each byte and queues work for the back end. Depends on dfv_pkg, dfv_intf.
`default_nettype none

module dfv_front import dfv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dfv_in_if.sink    in_i,
  dfv_cfg_if.sink   cfg_i,
  input  logic      full_i,
  output logic      push_o,
  output op_t       op_o
);

  logic        enabled_q;
  logic [15:0] magic_cfg_q;
  logic [15:0] pos_q, pos_d;
  logic [15:0] magic_q, magic_d;
  logic [15:0] len_q, len_d;
  logic [15:0] check_q, check_d;

  logic        accept;
  logic        last;
  logic        payload;
  logic [7:0]  b;
  logic [16:0] pos_ext, len_ext, len_d_ext, count;
  verdict_e    pre;

  assign in_i.ready  = !full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign b           = in_i.data_byte;
  assign last        = in_i.last_byte;
  assign pos_ext     = {1'b0, pos_q};
  assign len_ext     = {1'b0, len_q};
  assign len_d_ext   = {1'b0, len_d};
  assign count       = pos_ext + 17'd1;

  always_comb begin
    magic_d = magic_q;
    len_d   = len_q;
    check_d = check_q;
    payload = 1'b0;
    if (pos_q < 16'd2) begin
      magic_d = {magic_q[7:0], b};
    end else if (pos_q < 16'(HDR_BYTES)) begin
      len_d = {len_q[7:0], b};
    end else if ((pos_q - 16'(HDR_BYTES)) < len_q) begin
      payload = 1'b1;
    end else if (pos_ext == len_ext + 17'(HDR_BYTES) ||
                 pos_ext == len_ext + 17'(CHK_LAST_OFS)) begin
      check_d = {check_q[7:0], b};
    end
    pos_d = (&pos_q) ? pos_q : pos_q + 16'd1;
  end

  always_comb begin
    if (count < 17'(FRAME_OVERHEAD)) begin
      pre = VERDICT_SHORT;
    end else if (magic_d != magic_cfg_q) begin
      pre = VERDICT_BAD_MAGIC;
    end else if (len_d_ext > 17'(MAX_PAYLOAD) ||
                 len_d_ext + 17'(FRAME_OVERHEAD) > count) begin
      pre = VERDICT_BAD_LEN;
    end else begin
      pre = VERDICT_OK;
    end
  end

  always_comb begin
    op_o.kind    = !enabled_q ? OP_CLEAR : (last ? OP_VERDICT : OP_PAYLOAD);
    op_o.data    = b;
    op_o.payload = payload;
    op_o.pass    = (magic_q == magic_cfg_q) && (len_ext <= 17'(MAX_PAYLOAD));
    op_o.pre     = pre;
    op_o.check   = check_d;
    op_o.flen    = (pre == VERDICT_OK) ? len_d[8:0] : 9'd0;
  end

  assign push_o = accept && (!enabled_q || last || payload);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b0;
      magic_cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ENABLED: enabled_q   <= cfg_i.data[0];
        CFG_MAGIC:   magic_cfg_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      magic_q <= '0;
      len_q   <= '0;
      check_q <= '0;
    end else if (accept) begin
      // drop the frame on a disabled byte or at the end of the datagram
      if (!enabled_q || last) begin
        pos_q   <= '0;
        magic_q <= '0;
        len_q   <= '0;
        check_q <= '0;
      end else begin
        pos_q   <= pos_d;
        magic_q <= magic_d;
        len_q   <= len_d;
        check_q <= check_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/dfv_queue.sv =====
// Short register queue of work items between front and back end.
// Depends on dfv_pkg.
`default_nettype none

module dfv_queue import dfv_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_data_i,
  output logic full_o,
  input  logic pop_i,
  output op_t  pop_data_o,
  output logic empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  op_t           slots_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST_IDX) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST_IDX) ? '0 : rd_q + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/dfv_back.sv =====
// Back end: Fletcher-16 running sums, checksum compare and output register.
// Depends on dfv_pkg, dfv_intf.
`default_nettype none

module dfv_back import dfv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  op_t        op_i,
  output logic       pop_o,
  dfv_out_if.source  out_o
);

  logic [7:0] lo_q, hi_q, lo_upd, hi_upd, lo_v, hi_v;
  logic       out_valid_q, out_valid_d;
  logic       kind_q;
  logic [7:0] data_q;
  verdict_e   verdict_q, verdict_d;
  logic [8:0] flen_q;
  logic       emit_payload, emit_verdict;

  assign pop_o  = !empty_i && (!out_valid_q || out_o.ready);
  assign lo_upd = add_mod255(lo_q, op_i.data);
  assign hi_upd = add_mod255(hi_q, lo_upd);
  assign lo_v   = op_i.payload ? lo_upd : lo_q;
  assign hi_v   = op_i.payload ? hi_upd : hi_q;

  assign emit_payload = pop_o && (op_i.kind == OP_PAYLOAD) && op_i.pass;
  assign emit_verdict = pop_o && (op_i.kind == OP_VERDICT);

  always_comb begin
    verdict_d = op_i.pre;
    if (op_i.pre == VERDICT_OK && op_i.check != {hi_v, lo_v}) begin
      verdict_d = VERDICT_MISMATCH;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (emit_payload || emit_verdict) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        case (op_i.kind)
          OP_PAYLOAD: begin
            lo_q <= lo_upd;
            hi_q <= hi_upd;
          end
          OP_VERDICT, OP_CLEAR: begin
            lo_q <= '0;
            hi_q <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_payload) begin
      kind_q    <= 1'b0;
      data_q    <= op_i.data;
      verdict_q <= VERDICT_OK;
      flen_q    <= '0;
    end else if (emit_verdict) begin
      kind_q    <= 1'b1;
      data_q    <= '0;
      verdict_q <= verdict_d;
      flen_q    <= op_i.flen;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.item_kind    = kind_q;
  assign out_o.payload_out  = data_q;
  assign out_o.verdict      = verdict_q;
  assign out_o.frame_length = flen_q;

endmodule

`default_nettype wire

// ===== sv/datagram_frame_validator.sv =====
// Top level of the datagram frame validator: front end, work queue, back end.
// Depends on dfv_pkg, dfv_intf, dfv_front, dfv_queue, dfv_back.
//
//  Port    Dir  Handshake     Carries
//  in_i    in   valid/ready   data_byte, last_byte
//  out_o   out  valid/ready   item_kind, payload_out, verdict, frame_length
//  cfg_i   in   valid/ready   index, data (0 enabled, 1 magic_word); ready is always high
//
// One byte per cycle sustained while the queue is not full; a result is queued, then registered.
// Unless the output stalls, the back end retires one queued transaction per cycle into a single
// output register. Reset clears configuration, frame state, running sums and the queue at once.
// A stalled output backs up the queue; in_i.ready falls once the queue is full.
`default_nettype none

module datagram_frame_validator import dfv_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dfv_in_if.sink    in_i,
  dfv_out_if.source out_o,
  dfv_cfg_if.sink   cfg_i
);

  logic push, pop, full, empty;
  op_t  push_op, pop_op;

  dfv_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .op_o   (push_op)
  );

  dfv_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_op),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_op),
    .empty_o     (empty)
  );

  dfv_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .op_i    (pop_op),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ===== sv/dfv_checker.sv =====
// Port-level checks of the result channel, bound to the top level.
// Depends on dfv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dfv_checker import dfv_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       item_kind_i,
  input logic [7:0] payload_out_i,
  input logic [2:0] verdict_i,
  input logic [8:0] frame_length_i
);

  `DFV_ASSERT(a_out_valid_held, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)

  `DFV_ASSERT_HOLD(a_out_data_held, clk_i, rst_ni, out_valid_i && !out_ready_i, {item_kind_i, payload_out_i, verdict_i, frame_length_i})

  // verdict items carry no byte; only ok or mismatch report a length
  `DFV_ASSERT(a_verdict_fields, clk_i, rst_ni, out_valid_i && item_kind_i |-> payload_out_i == 8'd0 && (frame_length_i == 9'd0 || verdict_i == VERDICT_OK || verdict_i == VERDICT_MISMATCH))

  `DFV_ASSERT(a_payload_fields, clk_i, rst_ni, out_valid_i && !item_kind_i |-> verdict_i == VERDICT_OK && frame_length_i == 9'd0)

endmodule

bind datagram_frame_validator dfv_checker u_dfv_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .item_kind_i    (out_o.item_kind),
  .payload_out_i  (out_o.payload_out),
  .verdict_i      (out_o.verdict),
  .frame_length_i (out_o.frame_length)
);

`default_nettype wire

// ===== tb/sv/datagram_frame_validator_tb.sv =====
// Self-checking bench for datagram_frame_validator: directed frames, then random datagrams.
// Depends on dfv_pkg, dfv_intf and the validator RTL; results are checked in order.
`timescale 1ns / 100ps

module datagram_frame_validator_tb;
  import dfv_pkg::*;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam int unsigned POS_LIMIT       = 65535;
  localparam int unsigned SETTLE_CYCLES   = 4 * QUEUE_DEPTH + 4;
  localparam int unsigned STALL_LIMIT     = 4000;
  localparam int unsigned PHASES          = 6;
  localparam int unsigned ITEMS_PER_PHASE = 180;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_out;
    verdict_e    verdict;
    logic [8:0]  frame_length;
  } frame_result_t;

  typedef enum logic [1:0] {
    ROW_CFG,         // register write
    ROW_BYTE_NONE,   // byte that must give no result
    ROW_BYTE_ITEM,   // byte with the result typed in the row
    ROW_BYTE_MODEL   // byte whose result comes from the frame tracker
  } row_e;

  typedef struct packed {
    row_e                 act;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [15:0]          value;
    logic                 last;
    logic [16:0]          rep;
    frame_result_t        item;
  } plan_row_t;

  localparam frame_result_t NO_ITEM = '0;

  localparam plan_row_t DIRECTED_PLAN [34] = '{
    // ignored: block is disabled out of reset
    '{ROW_BYTE_NONE,  '0,          16'h00FF, 1'b1, 17'd1,     NO_ITEM},
    '{ROW_CFG,        CFG_MAGIC,   16'hFFFF, 1'b0, 17'd1,     NO_ITEM},
    '{ROW_CFG,        CFG_ENABLED, 16'h0001, 1'b0, 17'd1,     NO_ITEM},
    // one byte datagram
    '{ROW_BYTE_ITEM,  '0,          16'h0000, 1'b1, 17'd1,
      '{KIND_VERDICT, 8'h00, VERDICT_SHORT, 9'd0}},
    // magic FF00 against FFFF
    '{ROW_BYTE_NONE,  '0,          16'h00FF, 1'b0, 17'd1,     NO_ITEM},
    '{ROW_BYTE_NONE,  '0,          16'h0000, 1'b0, 17'd4,     NO_ITEM},
    '{ROW_BYTE_ITEM,  '0,          16'h0000, 1'b1, 17'd1,
      '{KIND_VERDICT, 8'h00, VERDICT_BAD_MAGIC, 9'd0}},
    // length 257, one over the maximum
    '{ROW_BYTE_NONE,  '0,          16'h00FF, 1'b0, 17'd2,     NO_ITEM},
    '{ROW_BYTE_NONE,  '0,          16'h0001, 1'b0, 17'd2,     NO_ITEM},
    '{ROW_BYTE_NONE,  '0,          16'h0000, 1'b0, 17'd1,     NO_ITEM},
    '{ROW_BYTE_ITEM,  '0,          16'h0000, 1'b1, 17'd1,
      '{KIND_VERDICT, 8'h00, VERDICT_BAD_LEN, 9'd0}},
    // one payload byte, wrong checksum, trailing byte ignored
    '{ROW_BYTE_NONE,  '0,          16'h00FF, 1'b0, 17'd2,     NO_ITEM},
    '{ROW_BYTE_NONE,  '0,          16'h0000, 1'b0, 17'd1,     NO_ITEM},
    '{ROW_BYTE_NONE,  '0,          16'h0001, 1'b0, 17'd1,     NO_ITEM},
    '{ROW_BYTE_MODEL, '0,          16'h0080, 1'b0, 17'd1,     NO_ITEM},
    '{ROW_BYTE_NONE,  '0,          16'h0000, 1'b0, 17'd1,     NO_ITEM},
    '{ROW_BYTE_NONE,  '0,          16'h0001, 1'b0, 17'd1,     NO_ITEM},
    '{ROW_BYTE_ITEM,  '0,          16'h007E, 1'b1, 17'd1,
      '{KIND_VERDICT, 8'h00, VERDICT_MISMATCH, 9'd1}},
    // header claims 5 bytes, datagram ends after the second payload byte
    '{ROW_BYTE_NONE,  '0,          16'h00FF, 1'b0, 17'd2,     NO_ITEM},
    '{ROW_BYTE_NONE,  '0,          16'h0000, 1'b0, 17'd1,     NO_ITEM},
    '{ROW_BYTE_NONE,  '0,          16'h0005, 1'b0, 17'd1,     NO_ITEM},
    '{ROW_BYTE_MODEL, '0,          16'h0000, 1'b0, 17'd1,     NO_ITEM},
    '{ROW_BYTE_ITEM,  '0,          16'h0000, 1'b1, 17'd1,
      '{KIND_VERDICT, 8'h00, VERDICT_BAD_LEN, 9'd0}},
    // good frame followed by padding
    '{ROW_BYTE_NONE,  '0,          16'h00FF, 1'b0, 17'd2,     NO_ITEM},
    '{ROW_BYTE_NONE,  '0,          16'h0000, 1'b0, 17'd1,     NO_ITEM},
    '{ROW_BYTE_NONE,  '0,          16'h0002, 1'b0, 17'd1,     NO_ITEM},
    '{ROW_BYTE_MODEL, '0,          16'h00FF, 1'b0, 17'd1,     NO_ITEM},
    '{ROW_BYTE_MODEL, '0,          16'h0000, 1'b0, 17'd1,     NO_ITEM},
    '{ROW_BYTE_NONE,  '0,          16'h0000, 1'b0, 17'd2,     NO_ITEM},
    '{ROW_BYTE_NONE,  '0,          16'h00A5, 1'b0, 17'd3,     NO_ITEM},
    '{ROW_BYTE_ITEM,  '0,          16'h00A5, 1'b1, 17'd1,
      '{KIND_VERDICT, 8'h00, VERDICT_OK, 9'd2}},
    // all-zero frame under magic zero
    '{ROW_CFG,        CFG_MAGIC,   16'h0000, 1'b0, 17'd1,     NO_ITEM},
    '{ROW_BYTE_NONE,  '0,          16'h0000, 1'b0, 17'd5,     NO_ITEM},
    '{ROW_BYTE_ITEM,  '0,          16'h0000, 1'b1, 17'd1,
      '{KIND_VERDICT, 8'h00, VERDICT_OK, 9'd0}}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dfv_in_if  in_if ();
  dfv_out_if out_if ();
  dfv_cfg_if cfg_if ();

  datagram_frame_validator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Frame tracker state and its copy of the registers
  logic        cfg_enabled;
  logic [15:0] cfg_magic;
  int unsigned rx_pos;
  logic [15:0] hdr_magic;
  logic [15:0] hdr_len;
  int unsigned sum_lo;
  int unsigned sum_hi;
  logic [15:0] rx_check;

  frame_result_t deframed_q [$];

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned items_sent;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  function automatic void clear_frame();
    rx_pos    = 0;
    hdr_magic = '0;
    hdr_len   = '0;
    sum_lo    = 0;
    sum_hi    = 0;
    rx_check  = '0;
  endfunction

  // Advance the frame tracker by one byte; returns the number of results queued.
  function automatic int deframe_byte(input logic [7:0] b, input logic l);
    int unsigned   p;
    int unsigned   cnt;
    logic          in_payload;
    frame_result_t r;
    p          = rx_pos;
    in_payload = 1'b0;
    r          = '0;
    if (!cfg_enabled) begin
      clear_frame();
      return 0;
    end
    if (p < 2) begin
      hdr_magic = {hdr_magic[7:0], b};
    end else if (p < HDR_BYTES) begin
      hdr_len = {hdr_len[7:0], b};
    end else if (p - HDR_BYTES < hdr_len) begin
      in_payload = 1'b1;
      sum_lo     = (sum_lo + b) % 255;
      sum_hi     = (sum_hi + sum_lo) % 255;
    end else if (p == HDR_BYTES + hdr_len || p == HDR_BYTES + hdr_len + 1) begin
      rx_check = {rx_check[7:0], b};
    end
    if (p < POS_LIMIT) rx_pos = p + 1;

    if (l) begin
      cnt         = p + 1;
      r.item_kind = KIND_VERDICT;
      if (cnt < FRAME_OVERHEAD) r.verdict = VERDICT_SHORT;
      else if (hdr_magic != cfg_magic) r.verdict = VERDICT_BAD_MAGIC;
      else if (hdr_len > MAX_PAYLOAD || hdr_len + FRAME_OVERHEAD > cnt)
        r.verdict = VERDICT_BAD_LEN;
      else if (rx_check != ((sum_hi << 8) | sum_lo)) r.verdict = VERDICT_MISMATCH;
      else r.verdict = VERDICT_OK;
      if (r.verdict == VERDICT_OK || r.verdict == VERDICT_MISMATCH)
        r.frame_length = hdr_len[8:0];
      clear_frame();
      deframed_q.push_back(r);
      return 1;
    end
    if (in_payload && hdr_magic == cfg_magic && hdr_len <= MAX_PAYLOAD) begin
      r.item_kind   = KIND_PAYLOAD;
      r.payload_out = b;
      deframed_q.push_back(r);
      return 1;
    end
    return 0;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l, output int made);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= l;
    do @(posedge clk_i); while (!in_if.ready);
    if (cfg_enabled) items_sent++;
    made = deframe_byte(b, l);
  endtask

  // Hold the input until every result is out and the pipeline has emptied.
  task automatic drain_and_settle();
    in_if.valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_ENABLED: cfg_enabled = val[0];
      CFG_MAGIC:   cfg_magic   = val;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_directed();
    int made;
    foreach (DIRECTED_PLAN[i]) begin
      if (DIRECTED_PLAN[i].act == ROW_CFG) begin
        drain_and_settle();
        write_reg(DIRECTED_PLAN[i].reg_idx, DIRECTED_PLAN[i].value);
      end else begin
        repeat (DIRECTED_PLAN[i].rep) begin
          send_byte(DIRECTED_PLAN[i].value[7:0], DIRECTED_PLAN[i].last, made);
          // typed rows replace whatever the tracker queued
          if (DIRECTED_PLAN[i].act != ROW_BYTE_MODEL) begin
            if (made != 0) void'(deframed_q.pop_back());
            if (DIRECTED_PLAN[i].act == ROW_BYTE_ITEM)
              deframed_q.push_back(DIRECTED_PLAN[i].item);
          end
        end
      end
    end
  endtask

  // Mostly well-formed frames with random content; some noise, cuts and bad fields.
  task automatic send_datagram(input logic [15:0] magic_v, input bit partial);
    logic [7:0]  frame [$];
    logic [15:0] len;
    logic [15:0] sum16;
    logic [7:0]  b;
    int unsigned pick;
    int unsigned npay;
    int unsigned s1;
    int unsigned s2;
    int unsigned cut;
    int          made;
    pick = $urandom_range(99);
    if (pick < 5) begin
      repeat ($urandom_range(1, 12)) frame.push_back(8'($urandom));
    end else begin
      pick = $urandom_range(99);
      if (pick < 65)      len = 16'($urandom_range(0, 12));
      else if (pick < 85) len = 16'($urandom_range(13, 48));
      else if (pick < 90) len = 16'($urandom_range(49, MAX_PAYLOAD - 1));
      else if (pick < 93) len = 16'(MAX_PAYLOAD);
      else                len = 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
      if ($urandom_range(99) < 8) magic_v ^= 16'(1 << $urandom_range(15));
      frame.push_back(magic_v[15:8]);
      frame.push_back(magic_v[7:0]);
      frame.push_back(len[15:8]);
      frame.push_back(len[7:0]);
      npay = (len > MAX_PAYLOAD) ? $urandom_range(0, 16) : len;
      s1 = 0;
      s2 = 0;
      repeat (npay) begin
        b = 8'($urandom);
        frame.push_back(b);
        s1 = (s1 + b) % 255;
        s2 = (s2 + s1) % 255;
      end
      sum16 = {s2[7:0], s1[7:0]};
      if ($urandom_range(99) < 8) sum16 ^= 16'(1 << $urandom_range(15));
      frame.push_back(sum16[15:8]);
      frame.push_back(sum16[7:0]);
      if ($urandom_range(99) < 15)
        repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom));
      if ($urandom_range(99) < 10) begin
        cut   = $urandom_range(1, frame.size());
        frame = frame[0:cut-1];
      end
    end
    if (partial) begin
      cut   = $urandom_range(1, frame.size());
      frame = frame[0:cut-1];
    end
    foreach (frame[i]) send_byte(frame[i], !partial && (i == frame.size() - 1), made);
  endtask

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    frame_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (deframed_q.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatches++;
      end else begin
        want = deframed_q.pop_front();
        compare_field("item_kind", 16'(want.item_kind), 16'(out_if.item_kind));
        compare_field("payload_out", 16'(want.payload_out), 16'(out_if.payload_out));
        compare_field("verdict", 16'(want.verdict), 16'(out_if.verdict));
        compare_field("frame_length", 16'(want.frame_length), 16'(out_if.frame_length));
      end
    end
  end

  always @(posedge clk_i) begin
    out_if.ready <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
  end

  // Stop a run that makes no progress on any channel.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL datagram_frame_validator");
      $finish;
    end
  end

  initial begin
    int          made;
    int unsigned start;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_ENABLED;
    cfg_if.data     = '0;
    cfg_enabled     = 1'b0;
    cfg_magic       = '0;
    items_sent      = 0;
    tx_idle_pct     = 20;
    rx_idle_pct     = 70;
    clear_frame();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_and_settle();
      if (ph < 2) begin
        tx_idle_pct = 20;
        rx_idle_pct = 70;
      end else if (ph < 4) begin
        tx_idle_pct = 70;
        rx_idle_pct = 20;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (ph % 2 == 1) begin
        // break off a datagram, then feed bytes while disabled to clear it
        send_datagram(cfg_magic, 1'b1);
        drain_and_settle();
        write_reg(CFG_ENABLED, 16'h0000);
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'($urandom_range(1)), made);
        drain_and_settle();
        write_reg(CFG_ENABLED, 16'h0001);
      end
      case (ph)
        0:       write_reg(CFG_MAGIC, 16'h0000);
        1:       write_reg(CFG_MAGIC, 16'hFFFF);
        default: write_reg(CFG_MAGIC, 16'($urandom));
      endcase
      start = items_sent;
      while (items_sent - start < ITEMS_PER_PHASE) begin
        send_datagram(cfg_magic, 1'b0);
        if ($urandom_range(49) == 0) drain_and_settle();
      end
    end

    drain_and_settle();
    if (mismatches == 0) begin
      $display("PASS datagram_frame_validator");
    end else begin
      $display("FAIL datagram_frame_validator");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/dfv_pkg.sv
sv/dfv_intf.sv
sv/dfv_front.sv
sv/dfv_queue.sv
sv/dfv_back.sv
sv/datagram_frame_validator.sv
sv/dfv_checker.sv
tb/sv/datagram_frame_validator_tb.sv
